/* hdl/psu_pkg.sv */
package psu_pkg;

	localparam int PARTS_DEF = 64;
	localparam int DIMS_DEF = 8;
	localparam int FRAC_BITS_DEF = 16;
	localparam int GAIN_FRAC = 12;

	localparam logic [1:0] FUNC_LOAD_POS = 2'd0;
	localparam logic [1:0] FUNC_LOAD_BND = 2'd1;
	localparam logic [1:0] FUNC_MOVE = 2'd2;
	localparam logic [1:0] FUNC_FIT = 2'd3;

	localparam logic [2:0] REG_PCOUNT = 3'd0;
	localparam logic [2:0] REG_DCOUNT = 3'd1;
	localparam logic [2:0] REG_INERTIA = 3'd2;
	localparam logic [2:0] REG_PGAIN = 3'd3;
	localparam logic [2:0] REG_GGAIN = 3'd4;

	localparam logic [63:0] SEED0 = 64'd123456789;
	localparam logic [63:0] SEED1 = 64'd362436069;
	localparam logic [63:0] SEED2 = 64'd521288629;
	localparam logic [63:0] SEED3 = 64'd88675123;

	// multiplier operand select
	typedef enum logic [1:0] {
		MUL_INERTIA,
		MUL_GAIN,
		MUL_PULL
	} mul_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_FIT_RD,
		ST_FIT_CMP,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_RD,
		ST_RD2,
		ST_T0,
		ST_G1,
		ST_T1,
		ST_G2,
		ST_T2,
		ST_SUM,
		ST_CLAMP,
		ST_EMIT,
		ST_FIT_EMIT
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647) r = 32'sh7fffffff;
		else if (x < -64'sd2147483648) r = 32'sh80000000;
		else r = x[31:0];
		return r;
	endfunction

endpackage

/* hdl/psu_mul.sv */
// Shared signed multiplier with floored shift and saturation, registered output.
module psu_mul (
	input  logic                clk,
	input  psu_pkg::mul_op_t    op,
	input  logic signed [31:0]  a,
	input  logic signed [32:0]  b,
	output logic signed [31:0]  prod_q
);
	logic signed [65:0] p;
	logic signed [65:0] sh;
	logic signed [63:0] clip;

	always_comb begin
		p = 66'(a) * 66'(b);
		case (op)
			psu_pkg::MUL_GAIN: sh = p >>> 16;
			default:           sh = p >>> psu_pkg::GAIN_FRAC;
		endcase
		if (sh > 66'sd2147483647) clip = 64'sh7fffffff;
		else if (sh < -66'sd2147483648) clip = -64'sd2147483648;
		else clip = 64'(sh);
	end

	always_ff @(posedge clk) begin
		prod_q <= psu_pkg::sat32(clip);
	end
endmodule

/* hdl/psu_rng.sv */
// xorshift128 over 64-bit words; advance on step, weight is the top 16 bits.
module psu_rng (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	output logic [15:0] weight
);
	logic [63:0] s0_q, s1_q, s2_q, s3_q;
	logic [63:0] t, w;

	always_comb begin
		t = s0_q ^ (s0_q << 11);
		w = s3_q ^ (s3_q >> 19) ^ (t ^ (t >> 8));
		weight = w[63:48];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_q <= psu_pkg::SEED0;
			s1_q <= psu_pkg::SEED1;
			s2_q <= psu_pkg::SEED2;
			s3_q <= psu_pkg::SEED3;
		end else if (step) begin
			s0_q <= s1_q;
			s1_q <= s2_q;
			s2_q <= s3_q;
			s3_q <= w;
		end
	end
endmodule

/* hdl/particle_swarm_update.sv */
// Particle swarm update engine. Pulse start while busy is low to hand in one
// word. Loads (func 0 position, func 1 bounds) are written when accepted,
// leave busy low and emit nothing. A fitness report for a used particle runs
// the personal/global best update: a read and a compare state, plus a copy
// read and write per used dimension when the personal best improves. Func 3
// then emits one result from its emit state; func 2 moves each used dimension
// through read, term, gain, sum, clamp and emit states using one shared
// multiplier (inertia term, two gain*random products, two pull products),
// each result showing on valid for exactly one cycle. The receiver cannot
// stall: read results on the cycle valid is high. After reset the block
// clears the velocity, personal best and global best position memories and
// presets the personal best fitnesses to the lowest value (busy stays high);
// configuration writes are taken throughout.
module particle_swarm_update #(
	parameter int PARTS = psu_pkg::PARTS_DEF,
	parameter int DIMS = psu_pkg::DIMS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         func,
	input  logic [5:0]         particle_index,
	input  logic [2:0]         dimension_index,
	input  logic signed [31:0] position_value,
	input  logic signed [31:0] upper_value,
	input  logic signed [31:0] fitness_value,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               valid,
	output logic [5:0]         out_particle,
	output logic [2:0]         out_dimension,
	output logic signed [31:0] new_position,
	output logic               best_improved,
	output logic signed [31:0] global_best_fitness,
	output logic               last
);
	localparam int PW = (PARTS > 1) ? $clog2(PARTS) : 1;
	localparam int DW = (DIMS > 1) ? $clog2(DIMS) : 1;
	localparam int CW = PW + DW;
	// One row of 2**DW words per particle, addressed as {particle, dimension}.
	localparam int CELLS = PARTS << DW;
	localparam int DCW = $clog2(DIMS + 1);
	localparam int PCW = $clog2(PARTS + 1);

	// Memories: positions, velocities, personal best positions, fitnesses.
	logic signed [31:0] pos_mem [CELLS];
	logic signed [31:0] vel_mem [CELLS];
	logic signed [31:0] pb_mem [CELLS];
	logic signed [31:0] pbf_mem [PARTS];
	logic signed [31:0] gb_pos_q [DIMS];
	logic signed [31:0] lo_q [DIMS];
	logic signed [31:0] hi_q [DIMS];
	logic signed [31:0] gbf_q;

	logic [6:0] pcount_q;
	logic [3:0] dcount_q;
	logic signed [15:0] w_q, c1_q, c2_q;

	psu_pkg::state_t state_q, state_d;
	logic [1:0] func_q;
	logic [PW-1:0] part_q;
	logic [DW-1:0] dim_q;
	logic signed [31:0] fit_q;
	logic improved_q, gimp_q;
	logic [CW-1:0] clr_q;
	logic signed [31:0] x_q, v_q, pb_q, pbf_q, t0_q, t1_q, g_q, nx_q;
	logic signed [31:0] prd;

	logic [DCW-1:0] nd;
	logic [PCW-1:0] np;
	logic [CW-1:0] slot;

	// Effective counts, saturated to [1, PARTS] and [1, DIMS].
	always_comb begin
		if (dcount_q == 4'd0) nd = DCW'(1);
		else if (32'(dcount_q) > DIMS) nd = DCW'(DIMS);
		else nd = DCW'(dcount_q);
		if (pcount_q == 7'd0) np = PCW'(1);
		else if (32'(pcount_q) > PARTS) np = PCW'(PARTS);
		else np = PCW'(pcount_q);
		slot = {part_q, dim_q};
	end

	// Multiplier operand routing.
	psu_pkg::mul_op_t mop;
	logic signed [31:0] ma;
	logic signed [32:0] mb;
	logic [15:0] rw;
	logic rstep;

	always_comb begin
		mop = psu_pkg::MUL_INERTIA;
		ma = 32'(w_q);
		mb = 33'(v_q);
		rstep = 1'b0;
		case (state_q)
			psu_pkg::ST_G1: begin
				mop = psu_pkg::MUL_GAIN; ma = 32'(c1_q); mb = 33'({1'b0, rw}); rstep = 1'b1;
			end
			psu_pkg::ST_G2: begin
				mop = psu_pkg::MUL_GAIN; ma = 32'(c2_q); mb = 33'({1'b0, rw}); rstep = 1'b1;
			end
			psu_pkg::ST_T1: begin
				mop = psu_pkg::MUL_PULL; ma = prd; mb = 33'(pb_q) - 33'(x_q);
			end
			psu_pkg::ST_T2: begin
				mop = psu_pkg::MUL_PULL; ma = prd; mb = 33'(gb_pos_q[dim_q]) - 33'(x_q);
			end
			default: ;
		endcase
	end

	psu_mul u_mul (.clk(clk), .op(mop), .a(ma), .b(mb), .prod_q(prd));
	psu_rng u_rng (.clk(clk), .arst_n(arst_n), .step(rstep), .weight(rw));

	logic accept;
	assign accept = start && !busy;

	// Next state.
	always_comb begin
		state_d = state_q;
		busy = (state_q != psu_pkg::ST_IDLE);
		case (state_q)
			psu_pkg::ST_IDLE:
				if (start) begin
					if ((func == psu_pkg::FUNC_MOVE || func == psu_pkg::FUNC_FIT)
					    && (PCW'(particle_index) < np) && (32'(particle_index) < PARTS))
						state_d = psu_pkg::ST_FIT_RD;
				end
			psu_pkg::ST_CLEAR: if (clr_q == CW'(CELLS - 1)) state_d = psu_pkg::ST_IDLE;
			psu_pkg::ST_FIT_RD: state_d = psu_pkg::ST_FIT_CMP;
			psu_pkg::ST_FIT_CMP:
				if (fit_q > pbf_q) state_d = psu_pkg::ST_COPY_RD;
				else if (func_q == psu_pkg::FUNC_FIT) state_d = psu_pkg::ST_FIT_EMIT;
				else state_d = psu_pkg::ST_RD;
			psu_pkg::ST_COPY_RD: state_d = psu_pkg::ST_COPY_WR;
			psu_pkg::ST_COPY_WR:
				if (DCW'(dim_q) + DCW'(1) == nd) begin
					if (func_q == psu_pkg::FUNC_FIT) state_d = psu_pkg::ST_FIT_EMIT;
					else state_d = psu_pkg::ST_RD;
				end else state_d = psu_pkg::ST_COPY_RD;
			psu_pkg::ST_RD: state_d = psu_pkg::ST_RD2;
			psu_pkg::ST_RD2: state_d = psu_pkg::ST_T0;
			psu_pkg::ST_T0: state_d = psu_pkg::ST_G1;
			psu_pkg::ST_G1: state_d = psu_pkg::ST_T1;
			psu_pkg::ST_T1: state_d = psu_pkg::ST_G2;
			psu_pkg::ST_G2: state_d = psu_pkg::ST_T2;
			psu_pkg::ST_T2: state_d = psu_pkg::ST_SUM;
			psu_pkg::ST_SUM: state_d = psu_pkg::ST_CLAMP;
			psu_pkg::ST_CLAMP: state_d = psu_pkg::ST_EMIT;
			psu_pkg::ST_EMIT:
				if (DCW'(dim_q) + DCW'(1) == nd) state_d = psu_pkg::ST_IDLE;
				else state_d = psu_pkg::ST_RD;
			psu_pkg::ST_FIT_EMIT: state_d = psu_pkg::ST_IDLE;
			default: state_d = psu_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psu_pkg::ST_CLEAR;
			clr_q <= '0;
			pcount_q <= 7'd64;
			dcount_q <= 4'd1;
			w_q <= 16'sd4096;
			c1_q <= 16'sd8192;
			c2_q <= 16'sd8192;
			gbf_q <= 32'sh80000000;
			valid <= 1'b0;
		end else begin
			state_q <= state_d;
			valid <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					psu_pkg::REG_PCOUNT: pcount_q <= cfg_data[6:0];
					psu_pkg::REG_DCOUNT: dcount_q <= cfg_data[3:0];
					psu_pkg::REG_INERTIA: w_q <= cfg_data;
					psu_pkg::REG_PGAIN: c1_q <= cfg_data;
					psu_pkg::REG_GGAIN: c2_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == psu_pkg::ST_CLEAR) clr_q <= clr_q + CW'(1);
			if (state_q == psu_pkg::ST_FIT_CMP && fit_q > pbf_q && fit_q > gbf_q)
				gbf_q <= fit_q;
			if (state_q == psu_pkg::ST_EMIT || state_q == psu_pkg::ST_FIT_EMIT)
				valid <= 1'b1;
		end
	end

	// Datapath and memories.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			part_q <= PW'(particle_index);
			dim_q <= '0;
			fit_q <= fitness_value;
			if (func == psu_pkg::FUNC_LOAD_POS && 32'(particle_index) < PARTS
			    && 32'(dimension_index) < DIMS)
				pos_mem[{PW'(particle_index), DW'(dimension_index)}] <= position_value;
			if (func == psu_pkg::FUNC_LOAD_BND && 32'(dimension_index) < DIMS) begin
				lo_q[DW'(dimension_index)] <= position_value;
				hi_q[DW'(dimension_index)] <= upper_value;
			end
		end
		case (state_q)
			psu_pkg::ST_CLEAR: begin
				vel_mem[clr_q] <= '0;
				pb_mem[clr_q] <= '0;
				if (clr_q[DW-1:0] == '0) pbf_mem[clr_q[CW-1:DW]] <= 32'sh80000000;
				if (clr_q < CW'(DIMS)) gb_pos_q[clr_q[DW-1:0]] <= '0;
			end
			psu_pkg::ST_FIT_RD: pbf_q <= pbf_mem[part_q];
			psu_pkg::ST_FIT_CMP: begin
				improved_q <= fit_q > pbf_q;
				gimp_q <= fit_q > gbf_q;
				if (fit_q > pbf_q) pbf_mem[part_q] <= fit_q;
			end
			psu_pkg::ST_COPY_RD: x_q <= pos_mem[slot];
			psu_pkg::ST_COPY_WR: begin
				pb_mem[slot] <= x_q;
				if (gimp_q) gb_pos_q[dim_q] <= x_q;
				dim_q <= (DCW'(dim_q) + DCW'(1) == nd) ? '0 : dim_q + DW'(1);
			end
			psu_pkg::ST_RD: begin
				x_q <= pos_mem[slot];
				v_q <= vel_mem[slot];
				pb_q <= pb_mem[slot];
			end
			psu_pkg::ST_T0: ;
			psu_pkg::ST_G1: t0_q <= prd;
			psu_pkg::ST_G2: t1_q <= prd;
			psu_pkg::ST_SUM: begin
				v_q <= psu_pkg::sat32(64'(t0_q) + 64'(t1_q) + 64'(prd));
			end
			psu_pkg::ST_CLAMP: begin
				nx_q <= psu_pkg::sat32(64'(x_q) + 64'(v_q));
			end
			psu_pkg::ST_EMIT: begin
				vel_mem[slot] <= v_q;
				pos_mem[slot] <= g_q;
				dim_q <= dim_q + DW'(1);
			end
			default: ;
		endcase
	end

	// Clamp against bounds, upper test first.
	always_comb begin
		if (nx_q > hi_q[dim_q]) g_q = hi_q[dim_q];
		else if (nx_q < lo_q[dim_q]) g_q = lo_q[dim_q];
		else g_q = nx_q;
	end

	always_ff @(posedge clk) begin
		if (state_q == psu_pkg::ST_EMIT || state_q == psu_pkg::ST_FIT_EMIT) begin
			out_particle <= 6'(part_q);
			best_improved <= improved_q;
			global_best_fitness <= gbf_q;
			if (state_q == psu_pkg::ST_EMIT) begin
				out_dimension <= 3'(dim_q);
				new_position <= g_q;
				last <= (DCW'(dim_q) + DCW'(1) == nd);
			end else begin
				out_dimension <= '0;
				new_position <= '0;
				last <= 1'b1;
			end
		end
	end
endmodule
